/* rtl/core/vfs_pkg.sv */
// Shared types and constants of the VCOM flicker search block.
`default_nettype none

package vfs_pkg;

	// One input transaction: a start request or one flicker measurement.
	typedef struct packed {
		logic        mode;
		logic [15:0] flicker;
		logic        sensor_timeout;
		logic [15:0] elapsed_ms;
	} in_item_t;

	// One result transaction: the VCOM to apply next and a status code.
	typedef struct packed {
		logic [7:0] vcom;
		logic [2:0] status;
	} out_item_t;

	// Configuration register file as seen by the search logic.
	typedef struct packed {
		logic [7:0]  start_vcom;
		logic [7:0]  vcom_min;
		logic [7:0]  vcom_max;
		logic [15:0] target_flicker;
		logic [15:0] coarse_threshold;
		logic [15:0] time_limit_ms;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WARM,
		PH_COARSE0,
		PH_COARSE,
		PH_SAMPLE,
		PH_WALK,
		PH_CHECK,
		PH_DONE
	} phase_t;

	// Input mode codes.
	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_MEASURE = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_CONTINUE   = 3'd0;
	localparam logic [2:0] ST_SUCCESS    = 3'd1;
	localparam logic [2:0] ST_TIMEOUT    = 3'd2;
	localparam logic [2:0] ST_TIME_LIMIT = 3'd3;
	localparam logic [2:0] ST_RANGE      = 3'd4;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_VCOM       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VCOM_MIN         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VCOM_MAX         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FLICKER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COARSE_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT_MS    = 3'd5;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration reset values.
	localparam logic [7:0]  START_VCOM_RST       = 8'h8B;
	localparam logic [7:0]  VCOM_MIN_RST         = 8'h05;
	localparam logic [7:0]  VCOM_MAX_RST         = 8'hA0;
	localparam logic [15:0] TARGET_FLICKER_RST   = 16'd192;
	localparam logic [15:0] COARSE_THRESHOLD_RST = 16'd1600;
	localparam logic [15:0] TIME_LIMIT_MS_RST    = 16'd30000;

	// Search constants.
	localparam int unsigned VCOM_W = 12;
	localparam logic [1:0]  WARMUP_LAST    = 2'd2;
	localparam logic signed [VCOM_W-1:0] COARSE_STRIDE = 12'sd10;
	localparam logic signed [VCOM_W-1:0] JUMP_WALK     = 12'sd5;
	localparam logic [15:0] BEST_RESET     = 16'd4080;
	localparam logic [7:0]  BEST_VCOM_RST  = 8'h8B;
	localparam logic [2:0]  REVERSAL_LIMIT = 3'd3;

	// Stride is floor(flicker / 160) = floor(floor(flicker / 32) / 5); the
	// division by five is a multiply by ceil(2^18 / 5), exact for 16-bit values.
	localparam int unsigned STRIDE_W = 9;
	localparam logic [15:0] DIV5_MUL = 16'd52429;
	localparam int unsigned DIV5_SHIFT = 18;

endpackage

`default_nettype wire

/* rtl/core/vfs_stride.sv */
// Walk stride from a flicker value: max(1, floor(flicker / 160)).
`default_nettype none

module vfs_stride (
	input  wire logic [15:0]                  flicker,
	output logic      [vfs_pkg::STRIDE_W-1:0] stride
);

	logic [10:0] coarse_part;
	logic [26:0] product;
	logic [vfs_pkg::STRIDE_W-1:0] quotient;

	assign coarse_part = flicker[15:5];
	assign product = {16'd0, coarse_part} * {11'd0, vfs_pkg::DIV5_MUL};
	assign quotient = product[vfs_pkg::DIV5_SHIFT +: vfs_pkg::STRIDE_W];
	assign stride = (quotient == '0) ? vfs_pkg::STRIDE_W'(1) : quotient;

endmodule

`default_nettype wire

/* rtl/core/vfs_ctrl.sv */
// Search state registers, phase sequencer and next-VCOM datapath.
`default_nettype none

module vfs_ctrl #(
	parameter int unsigned SAMPLE_COUNT = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire vfs_pkg::in_item_t item,
	input  wire vfs_pkg::cfg_t     cfg,
	output vfs_pkg::out_item_t     result
);

	localparam int unsigned SCW = (SAMPLE_COUNT > 2) ? $clog2(SAMPLE_COUNT) : 1;
	localparam logic [SCW-1:0] SAMPLE_LAST = SCW'(SAMPLE_COUNT - 1);

	// Saturate a signed VCOM to the 8-bit output range.
	function automatic logic [7:0] sat_vcom(input logic signed [vfs_pkg::VCOM_W-1:0] v);
		logic [7:0] r;
		if (v[vfs_pkg::VCOM_W-1]) begin
			r = 8'd0;
		end else if (|v[vfs_pkg::VCOM_W-2:8]) begin
			r = 8'hFF;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic logic signed [vfs_pkg::VCOM_W-1:0] widen(input logic [7:0] v);
		return $signed({4'b0000, v});
	endfunction

	vfs_pkg::phase_t phase_q, phase_n;
	logic [1:0]  warm_q, warm_n;
	logic signed [vfs_pkg::VCOM_W-1:0] vcom_q, vcom_n;
	logic [15:0] best_flk_q, best_flk_n;
	logic [7:0]  best_vcom_q, best_vcom_n;
	logic [15:0] samp_flk_q, samp_flk_n;
	logic [7:0]  samp_vcom_q, samp_vcom_n;
	logic [SCW-1:0] samp_cnt_q, samp_cnt_n;
	logic        walk_down_q, walk_down_n;
	logic [2:0]  rev_q, rev_n;
	logic [2:0]  status;

	logic [vfs_pkg::STRIDE_W-1:0] stride;
	logic signed [vfs_pkg::VCOM_W-1:0] delta;
	logic        better, worse, coarse_hit, check_ok, time_over, warm_last, samp_last;
	logic [15:0] best_after;
	logic [2:0]  rev_sum;
	logic        rev_hit;

	vfs_stride u_stride (
		.flicker (item.flicker),
		.stride  (stride)
	);

	assign better     = item.flicker < best_flk_q;
	assign best_after = better ? item.flicker : best_flk_q;
	assign worse      = item.flicker > best_after;
	assign coarse_hit = item.flicker < cfg.coarse_threshold;
	assign check_ok   = item.flicker < cfg.target_flicker;
	assign time_over  = item.elapsed_ms > cfg.time_limit_ms;
	assign warm_last  = warm_q == vfs_pkg::WARMUP_LAST;
	assign samp_last  = samp_cnt_q == SAMPLE_LAST;
	assign rev_sum    = rev_q + {2'b00, worse};
	assign rev_hit    = rev_sum > vfs_pkg::REVERSAL_LIMIT;
	assign delta      = walk_down_q ? -$signed({3'b000, stride}) : $signed({3'b000, stride});

	// Datapath and result.
	always_comb begin
		logic signed [vfs_pkg::VCOM_W-1:0] vt;
		logic in_range;
		vt          = vcom_q;
		in_range    = 1'b0;
		vcom_n      = vcom_q;
		warm_n      = warm_q;
		best_flk_n  = best_flk_q;
		best_vcom_n = best_vcom_q;
		samp_flk_n  = samp_flk_q;
		samp_vcom_n = samp_vcom_q;
		samp_cnt_n  = samp_cnt_q;
		walk_down_n = walk_down_q;
		rev_n       = rev_q;
		status      = vfs_pkg::ST_CONTINUE;
		if (item.mode == vfs_pkg::MODE_START) begin
			vcom_n      = widen(cfg.start_vcom);
			best_vcom_n = cfg.start_vcom;
			best_flk_n  = vfs_pkg::BEST_RESET;
			warm_n      = 2'd0;
			samp_cnt_n  = '0;
			rev_n       = 3'd0;
			walk_down_n = 1'b0;
		end else if (phase_q == vfs_pkg::PH_IDLE || phase_q == vfs_pkg::PH_DONE) begin
			vcom_n = vcom_q;
		end else if (item.sensor_timeout) begin
			status = vfs_pkg::ST_TIMEOUT;
		end else if (phase_q == vfs_pkg::PH_WARM) begin
			warm_n = warm_q + 2'd1;
			if (warm_last) begin
				warm_n   = 2'd0;
				in_range = (vcom_q > widen(cfg.vcom_min)) && (vcom_q < widen(cfg.vcom_max));
				status   = in_range ? vfs_pkg::ST_CONTINUE : vfs_pkg::ST_RANGE;
			end
		end else begin
			if (better) begin
				best_flk_n  = item.flicker;
				best_vcom_n = vcom_q[7:0];
			end
			case (phase_q)
				vfs_pkg::PH_COARSE0: begin
					if (!coarse_hit) begin
						vt = widen(cfg.vcom_min) + vfs_pkg::COARSE_STRIDE;
					end
				end
				vfs_pkg::PH_COARSE: begin
					vt = vcom_q + vfs_pkg::COARSE_STRIDE;
				end
				vfs_pkg::PH_SAMPLE: begin
					if (samp_cnt_q == '0) begin
						samp_flk_n  = item.flicker;
						samp_vcom_n = vcom_q[7:0];
					end
					samp_cnt_n = samp_cnt_q + SCW'(1);
					vt = vcom_q + $signed({3'b000, stride});
					if (samp_last) begin
						walk_down_n = samp_flk_q < item.flicker;
						vt = (samp_flk_q < item.flicker) ?
							widen(samp_vcom_q) - 12'sd1 : vcom_q + 12'sd1;
					end
				end
				vfs_pkg::PH_WALK: begin
					rev_n = rev_sum;
					vt = vcom_q + delta + (worse ? delta : 12'sd0);
					if (rev_hit) begin
						vt = widen(best_vcom_n);
					end
				end
				default: begin
					if (!check_ok) begin
						walk_down_n = 1'b0;
						best_flk_n  = vfs_pkg::BEST_RESET;
						vt          = widen(cfg.vcom_min) + vfs_pkg::JUMP_WALK;
						rev_n       = 3'd0;
					end
				end
			endcase
			vcom_n   = vt;
			in_range = (vt > widen(cfg.vcom_min)) && (vt < widen(cfg.vcom_max));
			if (phase_q == vfs_pkg::PH_CHECK && check_ok) begin
				status = vfs_pkg::ST_SUCCESS;
			end else if (time_over) begin
				status = vfs_pkg::ST_TIME_LIMIT;
			end else begin
				status = in_range ? vfs_pkg::ST_CONTINUE : vfs_pkg::ST_RANGE;
			end
		end
		result.vcom   = sat_vcom(vcom_n);
		result.status = status;
	end

	// Phase sequencer.
	always_comb begin
		phase_n = phase_q;
		if (item.mode == vfs_pkg::MODE_START) begin
			phase_n = vfs_pkg::PH_WARM;
		end else if (status != vfs_pkg::ST_CONTINUE) begin
			phase_n = vfs_pkg::PH_DONE;
		end else begin
			unique case (phase_q)
				vfs_pkg::PH_WARM:    phase_n = warm_last ? vfs_pkg::PH_COARSE0 : vfs_pkg::PH_WARM;
				vfs_pkg::PH_COARSE0: phase_n = coarse_hit ? vfs_pkg::PH_SAMPLE : vfs_pkg::PH_COARSE;
				vfs_pkg::PH_COARSE:  phase_n = coarse_hit ? vfs_pkg::PH_SAMPLE : vfs_pkg::PH_COARSE;
				vfs_pkg::PH_SAMPLE:  phase_n = samp_last ? vfs_pkg::PH_WALK : vfs_pkg::PH_SAMPLE;
				vfs_pkg::PH_WALK:    phase_n = rev_hit ? vfs_pkg::PH_CHECK : vfs_pkg::PH_WALK;
				vfs_pkg::PH_CHECK:   phase_n = vfs_pkg::PH_WALK;
				default:             phase_n = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= vfs_pkg::PH_IDLE;
			warm_q      <= 2'd0;
			vcom_q      <= widen(vfs_pkg::START_VCOM_RST);
			best_flk_q  <= vfs_pkg::BEST_RESET;
			best_vcom_q <= vfs_pkg::BEST_VCOM_RST;
			samp_cnt_q  <= '0;
			walk_down_q <= 1'b0;
			rev_q       <= 3'd0;
		end else if (advance) begin
			phase_q     <= phase_n;
			warm_q      <= warm_n;
			vcom_q      <= vcom_n;
			best_flk_q  <= best_flk_n;
			best_vcom_q <= best_vcom_n;
			samp_cnt_q  <= samp_cnt_n;
			walk_down_q <= walk_down_n;
			rev_q       <= rev_n;
		end
	end

	// Sample capture holds no reset value; it is written before it is read.
	always_ff @(posedge clk) begin
		if (advance) begin
			samp_flk_q  <= samp_flk_n;
			samp_vcom_q <= samp_vcom_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/vcom_flicker_search.sv */
// Top level of the VCOM flicker search: ports, configuration, input and result registers.
// An accepted transaction waits in the input register and has its result registered in the
// result register once that register is free, from where it can be taken.
// Throughput: one transaction per cycle, set by the single update pass between the input
// register and the result register; a stalled result register holds the input register.
// Reset: arst_n clears all control state asynchronously and loads the configuration defaults.
`default_nettype none

module vcom_flicker_search #(
	parameter int unsigned SAMPLE_COUNT = 3
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire vfs_pkg::in_item_t                in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output vfs_pkg::out_item_t                    out_data,
	input  wire logic                             cfg_we,
	input  wire logic [vfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	vfs_pkg::cfg_t      cfg_q;
	vfs_pkg::in_item_t  item_s1;
	logic               valid_s1;
	vfs_pkg::out_item_t result;
	vfs_pkg::out_item_t out_q;
	logic               out_valid_q;
	logic               advance;

	// The item in the input register is processed whenever the result register
	// is empty or its current transaction leaves in this cycle. The input
	// register in turn takes a new transaction whenever it is empty or advancing,
	// so one further transaction can wait in the input register while a result is held.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Configuration registers. Writes with an index beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_vcom       <= vfs_pkg::START_VCOM_RST;
			cfg_q.vcom_min         <= vfs_pkg::VCOM_MIN_RST;
			cfg_q.vcom_max         <= vfs_pkg::VCOM_MAX_RST;
			cfg_q.target_flicker   <= vfs_pkg::TARGET_FLICKER_RST;
			cfg_q.coarse_threshold <= vfs_pkg::COARSE_THRESHOLD_RST;
			cfg_q.time_limit_ms    <= vfs_pkg::TIME_LIMIT_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vfs_pkg::REG_START_VCOM:       cfg_q.start_vcom       <= cfg_wdata[7:0];
				vfs_pkg::REG_VCOM_MIN:         cfg_q.vcom_min         <= cfg_wdata[7:0];
				vfs_pkg::REG_VCOM_MAX:         cfg_q.vcom_max         <= cfg_wdata[7:0];
				vfs_pkg::REG_TARGET_FLICKER:   cfg_q.target_flicker   <= cfg_wdata;
				vfs_pkg::REG_COARSE_THRESHOLD: cfg_q.coarse_threshold <= cfg_wdata;
				vfs_pkg::REG_TIME_LIMIT_MS:    cfg_q.time_limit_ms    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// The search state and its single update pass.
	vfs_ctrl #(
		.SAMPLE_COUNT (SAMPLE_COUNT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Result register valid flag: loaded on advance, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* test/vcom_search_checker.sv */
// Checker for the VCOM flicker search: follows the search state and compares every result.
`timescale 1ns / 100ps

module vcom_search_checker #(
	parameter int SAMPLE_COUNT = 3
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire vfs_pkg::in_item_t               in_data,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire vfs_pkg::out_item_t              out_data,
	input  wire logic                            cfg_we,
	input  wire logic [vfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [vfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output int                                   errors,
	output int                                   pending,
	output int                                   checked,
	output logic [4:0]                           status_seen
);
	import vfs_pkg::*;

	localparam int WARMUP_MEAS = 3;
	localparam int COARSE_STEP = 10;
	localparam int RESTART_OFFSET = 5;
	localparam int STRIDE_DIV = 160;

	// Shadow copy of the register file and of the search state.
	cfg_t regs;
	phase_t phase;
	int warm_seen;
	int cur_vcom;
	int best_flk;
	int smp_flk;
	int smp_cnt;
	int rev_cnt;
	logic [7:0] best_vc;
	logic [7:0] smp_vc;
	logic walk_dn;

	out_item_t expected_q [$];
	out_item_t want;
	int err_cnt;
	int done_cnt;
	logic [4:0] seen;

	// Result with the current VCOM clamped to 8 bits; any nonzero status ends the search.
	function automatic out_item_t result_now(input logic [2:0] code);
		out_item_t r;
		if (cur_vcom < 0)
			r.vcom = 8'd0;
		else if (cur_vcom > 255)
			r.vcom = 8'hFF;
		else
			r.vcom = cur_vcom[7:0];
		r.status = code;
		if (code != ST_CONTINUE)
			phase = PH_DONE;
		return r;
	endfunction

	function automatic logic vcom_allowed();
		return cur_vcom > int'(regs.vcom_min) && cur_vcom < int'(regs.vcom_max);
	endfunction

	// Advances the search by one transaction and returns the result it should produce.
	function automatic out_item_t follow_search(input in_item_t it);
		int flk;
		int stride;
		int dir;
		int here;
		flk = it.flicker;
		if (it.mode == MODE_START) begin
			cur_vcom = regs.start_vcom;
			best_vc = regs.start_vcom;
			best_flk = BEST_RESET;
			warm_seen = 0;
			smp_cnt = 0;
			rev_cnt = 0;
			walk_dn = 1'b0;
			phase = PH_WARM;
			return result_now(ST_CONTINUE);
		end
		if (phase == PH_IDLE || phase == PH_DONE)
			return result_now(ST_CONTINUE);
		if (it.sensor_timeout)
			return result_now(ST_TIMEOUT);

		if (phase == PH_WARM) begin
			warm_seen++;
			if (warm_seen < WARMUP_MEAS)
				return result_now(ST_CONTINUE);
			warm_seen = 0;
			phase = PH_COARSE0;
			return result_now(vcom_allowed() ? ST_CONTINUE : ST_RANGE);
		end

		stride = flk / STRIDE_DIV;
		if (stride == 0)
			stride = 1;
		if (flk < best_flk) begin
			best_flk = flk;
			best_vc = cur_vcom[7:0];
		end
		dir = walk_dn ? -1 : 1;

		case (phase)
		PH_COARSE0: begin
			if (flk < int'(regs.coarse_threshold)) begin
				phase = PH_SAMPLE;
			end else begin
				cur_vcom = int'(regs.vcom_min) + COARSE_STEP;
				phase = PH_COARSE;
			end
		end
		PH_COARSE: begin
			cur_vcom += COARSE_STEP;
			if (flk < int'(regs.coarse_threshold))
				phase = PH_SAMPLE;
		end
		PH_SAMPLE: begin
			if (smp_cnt == 0) begin
				smp_flk = flk;
				smp_vc = cur_vcom[7:0];
			end
			here = cur_vcom;
			smp_cnt++;
			cur_vcom += stride;
			if (smp_cnt >= SAMPLE_COUNT) begin
				walk_dn = smp_flk < flk;
				cur_vcom = walk_dn ? int'(smp_vc) - 1 : here + 1;
				phase = PH_WALK;
			end
		end
		PH_WALK: begin
			cur_vcom += stride * dir;
			// A worse reading takes the stride again in the same direction.
			if (flk > best_flk) begin
				rev_cnt++;
				cur_vcom += stride * dir;
			end
			if (rev_cnt > int'(REVERSAL_LIMIT)) begin
				cur_vcom = best_vc;
				phase = PH_CHECK;
			end
		end
		default: begin
			if (flk < int'(regs.target_flicker))
				return result_now(ST_SUCCESS);
			walk_dn = 1'b0;
			best_flk = BEST_RESET;
			cur_vcom = int'(regs.vcom_min) + RESTART_OFFSET;
			rev_cnt = 0;
			phase = PH_WALK;
		end
		endcase

		if (it.elapsed_ms > regs.time_limit_ms)
			return result_now(ST_TIME_LIMIT);
		return result_now(vcom_allowed() ? ST_CONTINUE : ST_RANGE);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.start_vcom = START_VCOM_RST;
			regs.vcom_min = VCOM_MIN_RST;
			regs.vcom_max = VCOM_MAX_RST;
			regs.target_flicker = TARGET_FLICKER_RST;
			regs.coarse_threshold = COARSE_THRESHOLD_RST;
			regs.time_limit_ms = TIME_LIMIT_MS_RST;
			phase = PH_IDLE;
			warm_seen = 0;
			smp_cnt = 0;
			rev_cnt = 0;
			cur_vcom = START_VCOM_RST;
			best_flk = BEST_RESET;
			best_vc = BEST_VCOM_RST;
			smp_flk = 0;
			smp_vc = '0;
			walk_dn = 1'b0;
			expected_q.delete();
			err_cnt = 0;
			done_cnt = 0;
			seen = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_START_VCOM:       regs.start_vcom = cfg_wdata[7:0];
				REG_VCOM_MIN:         regs.vcom_min = cfg_wdata[7:0];
				REG_VCOM_MAX:         regs.vcom_max = cfg_wdata[7:0];
				REG_TARGET_FLICKER:   regs.target_flicker = cfg_wdata;
				REG_COARSE_THRESHOLD: regs.coarse_threshold = cfg_wdata;
				REG_TIME_LIMIT_MS:    regs.time_limit_ms = cfg_wdata;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, actual vcom %0d status %0d",
						$time, out_data.vcom, out_data.status);
				end else begin
					want = expected_q.pop_front();
					if (out_data.vcom !== want.vcom) begin
						err_cnt++;
						$display("%0t: vcom mismatch, expected %0d, actual %0d",
							$time, want.vcom, out_data.vcom);
					end
					if (out_data.status !== want.status) begin
						err_cnt++;
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, out_data.status);
					end
					done_cnt++;
					if (out_data.status <= ST_RANGE)
						seen[out_data.status] = 1'b1;
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(follow_search(in_data));
		end
		errors <= err_cnt;
		pending <= expected_q.size();
		checked <= done_cnt;
		status_seen <= seen;
	end

endmodule

/* test/tb.sv */
// Testbench top for the VCOM flicker search: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;
	import vfs_pkg::*;

	localparam int SAMPLES = 3;
	// The slowest legal run is far below this: about 1500 transactions, each
	// delayed at most by the longest sender gap and a mostly stalled receiver.
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 250;
	// Spare cycles after the last result let the block settle before registers change.
	localparam int SETTLE_CYCLES = 4;
	localparam int N_PLANS = 7;

	// Receiver stall patterns; each one lasts for a random stretch of cycles.
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int checked;
	logic [4:0] status_seen;

	int burst_left = 0;
	int sent_total = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int mode_left = 0;
	int stall_tick = 0;
	rx_pattern_t rx_pattern = RX_FREE;
	int cycles = 0;

	// Time limit currently programmed; keeps most elapsed times below it.
	logic [15:0] live_limit = TIME_LIMIT_MS_RST;
	cfg_t plan [N_PLANS];
	int plan_items [N_PLANS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vcom_flicker_search #(
		.SAMPLE_COUNT(SAMPLES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	vcom_search_checker #(
		.SAMPLE_COUNT(SAMPLES)
	) u_search_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.status_seen(status_seen)
	);

	// Receiver side. It switches between stall patterns on its own schedule.
	// When the sender asks for a long hold-off, the stall stays high until the
	// LONG_HOLD countdown here runs out, so that the block fills up and in turn
	// stalls its input while the sender keeps offering transactions.
	always @(posedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 300);
		end
		mode_left--;
		stall_tick++;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_pattern)
			RX_FREE: begin
				out_stall <= 1'b0;
			end
			RX_LIGHT: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			RX_HEAVY: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_stall <= (stall_tick % 5) < 2;
			end
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Offers one transaction and returns at the edge where it is accepted.
	// Transactions go out in bursts of random length; before a burst there is
	// a gap of random length, and half of the time no gap at all. Valid is only
	// lowered at the start of a gap, never between two back-to-back items.
	task automatic offer(input in_item_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		sent_total++;
	endtask

	// Drops valid at the edge of the last acceptance, then waits until every
	// result has been taken. The first edge lets the checker count the last
	// transaction before its pending count is trusted.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// A start request; its other fields are don't-care, so they are random.
	function automatic in_item_t start_item();
		in_item_t it;
		it.mode = MODE_START;
		it.flicker = 16'($urandom_range(0, 65535));
		it.sensor_timeout = 1'($urandom_range(0, 1));
		it.elapsed_ms = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic in_item_t measure_item(input logic [15:0] flk, input logic tout,
			input logic [15:0] el);
		in_item_t it;
		it.mode = MODE_MEASURE;
		it.flicker = flk;
		it.sensor_timeout = tout;
		it.elapsed_ms = el;
		return it;
	endfunction

	// Flicker readings lean toward small values so that the coarse sweep ends,
	// the walk sees both better and worse readings and the final check can
	// pass; the rest spans the whole 16-bit range with both extremes.
	function automatic in_item_t rand_measure();
		int pick;
		logic [15:0] flk;
		logic [15:0] el;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			flk = 16'($urandom_range(0, 320));
		else if (pick < 80)
			flk = 16'($urandom_range(0, 2000));
		else if (pick < 92)
			flk = 16'($urandom_range(0, 65535));
		else if (pick < 96)
			flk = 16'hFFFF;
		else
			flk = 16'h0000;
		if ($urandom_range(0, 99) < 94)
			el = 16'($urandom_range(0, live_limit));
		else
			el = 16'($urandom_range(0, 65535));
		return measure_item(flk, $urandom_range(0, 99) < 2, el);
	endfunction

	// Hand-picked sequence under the reset register values. It measures while
	// idle, runs warm-up, a coarse sweep of three steps, the direction samples
	// and a walk of four worse readings into the final check, which misses the
	// target and restarts the walk. A sensor timeout then ends the search, a
	// measurement after the end is ignored, and a second search runs out of
	// time right after its warm-up.
	task automatic run_directed();
		offer(measure_item(16'hFFFF, 1'b1, 16'hFFFF));
		offer(start_item());
		repeat (3) offer(measure_item(16'h0000, 1'b0, 16'd0));
		offer(measure_item(16'd2000, 1'b0, 16'd100));
		offer(measure_item(16'd1700, 1'b0, 16'd200));
		offer(measure_item(16'd100, 1'b0, 16'd300));
		offer(measure_item(16'd320, 1'b0, 16'd400));
		offer(measure_item(16'd480, 1'b0, 16'd500));
		offer(measure_item(16'd160, 1'b0, 16'd600));
		offer(measure_item(16'd500, 1'b0, 16'd700));
		offer(measure_item(16'd600, 1'b0, 16'd800));
		offer(measure_item(16'd700, 1'b0, 16'd900));
		offer(measure_item(16'd800, 1'b0, 16'd1000));
		offer(measure_item(16'd1000, 1'b0, 16'd1100));
		offer(measure_item(16'd0, 1'b1, 16'd1200));
		offer(measure_item(16'd50, 1'b0, 16'd1300));
		offer(start_item());
		repeat (3) offer(measure_item(16'd10, 1'b0, 16'd0));
		offer(measure_item(16'd10, 1'b0, 16'hFFFF));
	endtask

	// Random searches: each opens with a start request and continues with a
	// random number of measurements. A few starts land in the middle of a
	// search, and searches that end early leave trailing measurements that the
	// block must ignore.
	task automatic run_searches(input int n_items);
		int left;
		int len;
		left = n_items;
		while (left > 0) begin
			offer(start_item());
			left--;
			len = $urandom_range(4, 45);
			while (len > 0 && left > 0) begin
				if ($urandom_range(0, 99) < 3)
					offer(start_item());
				else
					offer(rand_measure());
				len--;
				left--;
			end
		end
	endtask

	initial begin : stimulus
		int p;

		// Register plans. The first keeps the reset values and is never written;
		// the others take every register to both of its extremes, give an empty
		// VCOM interval, a start value outside the interval, a narrow window and
		// two random settings.
		plan[0] = '{start_vcom: START_VCOM_RST, vcom_min: VCOM_MIN_RST,
			vcom_max: VCOM_MAX_RST, target_flicker: TARGET_FLICKER_RST,
			coarse_threshold: COARSE_THRESHOLD_RST, time_limit_ms: TIME_LIMIT_MS_RST};
		plan[1] = '{start_vcom: 8'd128, vcom_min: 8'd0, vcom_max: 8'd255,
			target_flicker: 16'hFFFF, coarse_threshold: 16'hFFFF, time_limit_ms: 16'hFFFF};
		plan[2] = '{start_vcom: 8'd255, vcom_min: 8'd255, vcom_max: 8'd0,
			target_flicker: 16'd0, coarse_threshold: 16'd0, time_limit_ms: 16'd0};
		plan[3] = '{start_vcom: 8'd0, vcom_min: 8'd0, vcom_max: 8'd2,
			target_flicker: 16'd100, coarse_threshold: 16'd0, time_limit_ms: 16'hFFFF};
		for (p = 4; p < 6; p++) begin
			plan[p].start_vcom = 8'($urandom_range(30, 220));
			plan[p].vcom_min = 8'($urandom_range(0, 25));
			plan[p].vcom_max = 8'($urandom_range(230, 255));
			plan[p].target_flicker = 16'($urandom_range(100, 1000));
			plan[p].coarse_threshold = 16'($urandom_range(200, 5000));
			plan[p].time_limit_ms = 16'($urandom_range(5000, 65535));
		end
		plan[6] = '{start_vcom: 8'd20, vcom_min: 8'd10, vcom_max: 8'd40,
			target_flicker: 16'd400, coarse_threshold: 16'd3000, time_limit_ms: 16'd20000};
		plan_items[0] = 240;
		plan_items[1] = 240;
		plan_items[2] = 80;
		plan_items[3] = 80;
		plan_items[4] = 320;
		plan_items[5] = 320;
		plan_items[6] = 200;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (p = 0; p < N_PLANS; p++) begin
			// Registers only change once the block is idle; waiting for all
			// results here is also the point where the sender pauses completely.
			if (p > 0) begin
				drain();
				write_reg(REG_START_VCOM, {8'd0, plan[p].start_vcom});
				write_reg(REG_VCOM_MIN, {8'd0, plan[p].vcom_min});
				write_reg(REG_VCOM_MAX, {8'd0, plan[p].vcom_max});
				write_reg(REG_TARGET_FLICKER, plan[p].target_flicker);
				write_reg(REG_COARSE_THRESHOLD, plan[p].coarse_threshold);
				write_reg(REG_TIME_LIMIT_MS, plan[p].time_limit_ms);
				cfg_we <= 1'b0;
			end
			live_limit = plan[p].time_limit_ms;
			if (p == 0)
				run_directed();
			// Back-pressure test: the receiver holds off while traffic continues.
			if (p == 4)
				hold_requests++;
			run_searches(plan_items[p]);
		end

		drain();

		$display("Covered %0d register settings with %0d transactions; %0d results compared.",
			N_PLANS, sent_total, checked);
		$display("Status codes returned (out of range, time limit, timeout, success, continue): %b",
			status_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
